// File: sv/ctmt_pkg.sv
// Shared types and constants for the counter table with maximum tracking.
`timescale 1ns / 1ps
`default_nettype none
package ctmt_pkg;

  localparam int unsigned NumCountersDef = 64;
  localparam int unsigned CountBitsDef   = 16;
  localparam int unsigned IndexW         = 6;
  localparam int unsigned OpW            = 2;
  localparam int unsigned ResValW        = 16;
  localparam int unsigned ResPopW        = 7;

  typedef enum logic [OpW-1:0] {
    OP_INC  = 2'd0,
    OP_DEC  = 2'd1,
    OP_CLR  = 2'd2,
    OP_READ = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_LAUNCH,
    ST_SCAN,
    ST_DELIVER
  } state_e;

  typedef struct packed {
    logic [OpW-1:0]    operation;
    logic [IndexW-1:0] index;
  } req_t;

  typedef struct packed {
    logic signed [ResValW-1:0] count_value;
    logic signed [ResValW-1:0] max_value;
    logic [ResPopW-1:0]        max_population;
  } res_t;

  // broadcast to every cell of the row
  typedef struct packed {
    logic              upd;
    op_e               op;
    logic [IndexW-1:0] index;
  } cell_cmd_t;

endpackage
`default_nettype wire

// File: sv/counter_table_max_tracker_unit.sv
// Top level: request control, row of counter cells and result register.
`timescale 1ns / 1ps
`default_nettype none
// Table of NUM_COUNTERS saturating signed counters, all zero after reset. Each request
// increments, decrements, clears or just reads one counter and returns that counter's new
// value, the table maximum and how many counters hold it. Every counter lives in its own
// cell; after the update a scan token walks the row one cell per cycle, each cell folding
// its value into the running maximum and holder count. A request passes the update, launch
// and scan states, then waits in the deliver state while the previous result is untaken,
// and is loaded into the output register. A new request is taken only once the result sits
// in the output register, so the unit works on one request at a time.
// An index beyond the table changes nothing and returns a count value of zero.
module counter_table_max_tracker_unit import ctmt_pkg::*; #(
  parameter int unsigned NUM_COUNTERS = NumCountersDef,
  parameter int unsigned COUNT_BITS   = CountBitsDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire req_t in_req_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output res_t      out_res_o
);

  localparam int unsigned PopW = $clog2(NUM_COUNTERS + 1);
  localparam logic signed [COUNT_BITS-1:0] BotVal = {1'b1, {(COUNT_BITS-1){1'b0}}};

  state_e    state_q, state_d;
  req_t      req_q;
  cell_cmd_t cmd;
  logic      launch;
  logic      load;
  logic      out_valid_q, out_valid_d;
  res_t      res_q;

  logic                         tok  [NUM_COUNTERS+1];
  logic signed [COUNT_BITS-1:0] best [NUM_COUNTERS+1];
  logic [PopW-1:0]              cnt  [NUM_COUNTERS+1];
  logic signed [COUNT_BITS-1:0] sel  [NUM_COUNTERS+1];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:    if (in_valid_i) state_d = ST_UPDATE;
      ST_UPDATE:  state_d = ST_LAUNCH;
      ST_LAUNCH:  state_d = ST_SCAN;
      ST_SCAN:    if (tok[NUM_COUNTERS]) state_d = ST_DELIVER;
      ST_DELIVER: if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = (state_q == ST_IDLE);
    launch     = (state_q == ST_LAUNCH);
    load       = (state_q == ST_DELIVER) && (!out_valid_q || out_ready_i);
    cmd.upd    = (state_q == ST_UPDATE);
    cmd.op     = op_e'(req_q.operation);
    cmd.index  = req_q.index;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      req_q <= in_req_i;
    end
    if (load) begin
      res_q.count_value    <= ResValW'(sel[NUM_COUNTERS]);
      res_q.max_value      <= ResValW'(best[NUM_COUNTERS]);
      res_q.max_population <= ResPopW'(cnt[NUM_COUNTERS]);
    end
  end

  // seed of the scan: the lowest value, no holders, no addressed counter seen
  assign tok[0]  = launch;
  assign best[0] = BotVal;
  assign cnt[0]  = '0;
  assign sel[0]  = '0;

  for (genvar k = 0; k < NUM_COUNTERS; k++) begin : g_cell
    ctmt_cell #(
      .CountBits(COUNT_BITS),
      .PopW     (PopW),
      .CellId   (k)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .cmd_i (cmd),
      .tok_i (tok[k]),
      .best_i(best[k]),
      .cnt_i (cnt[k]),
      .sel_i (sel[k]),
      .tok_o (tok[k+1]),
      .best_o(best[k+1]),
      .cnt_o (cnt[k+1]),
      .sel_o (sel[k+1])
    );
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = res_q;

endmodule
`default_nettype wire

// File: sv/ctmt_cell.sv
// One counter of the table plus its stage of the running maximum scan.
`timescale 1ns / 1ps
`default_nettype none
module ctmt_cell import ctmt_pkg::*; #(
  parameter int unsigned CountBits = CountBitsDef,
  parameter int unsigned PopW      = 7,
  parameter int unsigned CellId    = 0
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire cell_cmd_t                   cmd_i,
  input  wire logic                        tok_i,
  input  wire logic signed [CountBits-1:0] best_i,
  input  wire logic [PopW-1:0]             cnt_i,
  input  wire logic signed [CountBits-1:0] sel_i,
  output logic                             tok_o,
  output logic signed [CountBits-1:0]      best_o,
  output logic [PopW-1:0]                  cnt_o,
  output logic signed [CountBits-1:0]      sel_o
);

  localparam logic signed [CountBits-1:0] TopVal = {1'b0, {(CountBits-1){1'b1}}};
  localparam logic signed [CountBits-1:0] BotVal = {1'b1, {(CountBits-1){1'b0}}};
  localparam bit Reachable = (CellId < (1 << IndexW));

  logic signed [CountBits-1:0] val_q, val_d;
  logic                        tok_q;
  logic signed [CountBits-1:0] best_q, best_d;
  logic [PopW-1:0]             cnt_q, cnt_d;
  logic signed [CountBits-1:0] sel_q, sel_d;
  logic                        hit;

  assign hit = Reachable && (cmd_i.index == IndexW'(CellId));

  always_comb begin
    val_d = val_q;
    if (cmd_i.upd && hit) begin
      unique case (cmd_i.op)
        OP_INC:  if (val_q != TopVal) val_d = val_q + CountBits'(1);
        OP_DEC:  if (val_q != BotVal) val_d = val_q - CountBits'(1);
        OP_CLR:  val_d = '0;
        OP_READ: val_d = val_q;
        default: val_d = val_q;
      endcase
    end
  end

  // fold this counter into the partial maximum handed in from the left
  always_comb begin
    best_d = best_i;
    cnt_d  = cnt_i;
    if (val_q > best_i) begin
      best_d = val_q;
      cnt_d  = PopW'(1);
    end else if (val_q == best_i) begin
      cnt_d = cnt_i + PopW'(1);
    end
    sel_d = hit ? val_q : sel_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q <= '0;
      tok_q <= 1'b0;
    end else begin
      val_q <= val_d;
      tok_q <= tok_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tok_i) begin
      best_q <= best_d;
      cnt_q  <= cnt_d;
      sel_q  <= sel_d;
    end
  end

  assign tok_o  = tok_q;
  assign best_o = best_q;
  assign cnt_o  = cnt_q;
  assign sel_o  = sel_q;

endmodule
`default_nettype wire
